@@ sv/sse_pkg.sv @@
// Shared types, constants and helper functions of the substring search engine.
package sse_pkg;

    // Needle storage is fixed by the two 64-bit needle registers.
    localparam int NEEDLE_BYTES     = 16;
    localparam int CFG_DATA_WIDTH   = 64;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int LENGTH_WIDTH     = 5;
    localparam int MATCH_POS_WIDTH  = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_NEEDLE_LOW    = 2'd0,
        CFG_NEEDLE_HIGH   = 2'd1,
        CFG_NEEDLE_LENGTH = 2'd2,
        CFG_FOLD_CASE     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][7:0] needle;
        logic [LENGTH_WIDTH-1:0]      length;
        logic                         fold;
    } sse_cfg_t;

    // Maps ASCII upper case to lower case when folding is enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && (b >= 8'h41) && (b <= 8'h5A))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ sv/sse_if.sv @@
// Valid/ready channel interfaces for haystack bytes and search results.
interface sse_in_if;
    import sse_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] hay_byte;
    logic       last_byte;

    modport source (output valid, output hay_byte, output last_byte, input ready);
    modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

interface sse_out_if;
    import sse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [MATCH_POS_WIDTH-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

@@ sv/sse_cfg_regs.sv @@
// Configuration register file holding the needle, its length and the fold mode.
module sse_cfg_regs
    import sse_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output sse_cfg_t                   cfg
);

    logic [CFG_DATA_WIDTH-1:0] needle_low_reg;
    logic [CFG_DATA_WIDTH-1:0] needle_high_reg;
    logic [LENGTH_WIDTH-1:0]   needle_length_reg;
    logic                      fold_case_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
            needle_length_reg <= '0;
            fold_case_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NEEDLE_LOW:    needle_low_reg    <= cfg_data;
                CFG_NEEDLE_HIGH:   needle_high_reg   <= cfg_data;
                CFG_NEEDLE_LENGTH: needle_length_reg <= cfg_data[LENGTH_WIDTH-1:0];
                CFG_FOLD_CASE:     fold_case_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.needle = {needle_high_reg, needle_low_reg};
    assign cfg.length = needle_length_reg;
    assign cfg.fold   = fold_case_reg;

endmodule

@@ sv/sse_matcher.sv @@
// Parallel compare of the needle against the byte window ending at the newest byte.
module sse_matcher
    import sse_pkg::*;
#(
    parameter int NEEDLE_MAX     = 16,
    parameter int POSITION_WIDTH = 32
)
(
    input  sse_cfg_t                         cfg,
    input  logic [NEEDLE_MAX-1:0][7:0]       window,
    input  logic [POSITION_WIDTH-1:0]        seen_now,
    output logic                             hit,
    output logic [MATCH_POS_WIDTH-1:0]       match_pos
);

    localparam int LEN_W  = $clog2(NEEDLE_MAX + 1);
    localparam int IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int WIDE_W = (POSITION_WIDTH > MATCH_POS_WIDTH) ? POSITION_WIDTH
                                                               : MATCH_POS_WIDTH;

    logic [LEN_W-1:0]                len_eff;
    logic [NEEDLE_MAX-1:0][LEN_W-1:0] tap_sel;
    logic [NEEDLE_MAX-1:0]           byte_ok;
    logic [POSITION_WIDTH-1:0]       pos;
    logic [WIDE_W-1:0]               pos_wide;

    // A length above the window depth is treated as the full depth.
    assign len_eff = (cfg.length > LENGTH_WIDTH'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                             : cfg.length[LEN_W-1:0];

    // Needle byte k lines up with the window tap len-1-k; taps past len are ignored.
    for (genvar k = 0; k < NEEDLE_MAX; k++)
    begin : g_cmp
        assign tap_sel[k] = len_eff - LEN_W'(1) - LEN_W'(k);
        assign byte_ok[k] = (LEN_W'(k) >= len_eff) ||
                            (fold_byte(window[tap_sel[k][IDX_W-1:0]], cfg.fold) ==
                             fold_byte(cfg.needle[k], cfg.fold));
    end

    assign hit = (len_eff == '0) ||
                 ((seen_now >= POSITION_WIDTH'(len_eff)) && (&byte_ok));

    assign pos       = (len_eff == '0) ? '0 : (seen_now - POSITION_WIDTH'(len_eff));
    assign pos_wide  = WIDE_W'(pos);
    assign match_pos = pos_wide[MATCH_POS_WIDTH-1:0];

endmodule

@@ sv/substring_search_engine_unit.sv @@
// Top level of the substring search engine: input stage, search state and result register.
//
//  Channel   Dir  Word contents                      Accepted when
//  -------   ---  ---------------------------------  -----------------------------
//  in_ch     in   hay_byte, last_byte                in_ch.valid && in_ch.ready
//  out_ch    out  found, match_position              out_ch.valid && out_ch.ready
//  cfg_*     in   cfg_index, cfg_data                cfg_we high
//
// An accepted word waits in the input register; once the result register is
// free, the window compare loads its result, if any, into it, where it can be
// taken. A new word is accepted every cycle while results are taken; the
// input ready follows the result ready combinationally.
// Reset clears the needle registers, the window, the byte count and the
// match flag; after reset the block accepts words at once.
// When the result register is full and not taken, the input register holds
// its word and ready drops once both stages are occupied.
module substring_search_engine_unit
    import sse_pkg::*;
#(
    parameter int NEEDLE_MAX     = 16,
    parameter int POSITION_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    sse_in_if.sink                     in_ch,
    sse_out_if.source                  out_ch
);

    sse_cfg_t cfg;

    // Input stage holding one accepted word.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic [7:0] s1_byte_next;
    logic       s1_last_reg;
    logic       s1_last_next;

    // Search state: the most recent bytes (entry 0 newest), the byte count of
    // the current haystack and whether a match has already been reported.
    logic [NEEDLE_MAX-1:0][7:0] window_reg;
    logic [NEEDLE_MAX-1:0][7:0] window_next;
    logic [NEEDLE_MAX-1:0][7:0] window_shift;
    logic [POSITION_WIDTH-1:0]  bytes_seen_reg;
    logic [POSITION_WIDTH-1:0]  bytes_seen_next;
    logic [POSITION_WIDTH-1:0]  seen_now;
    logic                       match_done_reg;
    logic                       match_done_next;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_found_reg;
    logic                       out_found_next;
    logic [MATCH_POS_WIDTH-1:0] out_pos_reg;
    logic [MATCH_POS_WIDTH-1:0] out_pos_next;

    logic                       out_free;
    logic                       s1_fire;
    logic                       in_fire;
    logic                       hit;
    logic [MATCH_POS_WIDTH-1:0] match_pos;
    logic                       emit;

    sse_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register can take a new result when it is empty or being read.
    assign out_free = !out_valid_reg || out_ch.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_fire  = in_ch.valid && in_ch.ready;

    assign in_ch.ready = !s1_valid_reg || s1_fire;

    // The window as it stands once the word in the input stage is shifted in.
    always_comb
    begin
        window_shift[0] = s1_byte_reg;
        for (int j = 1; j < NEEDLE_MAX; j++)
        begin
            window_shift[j] = window_reg[j-1];
        end
    end

    // The byte count saturates at all ones.
    assign seen_now = (bytes_seen_reg == '1) ? bytes_seen_reg
                                             : (bytes_seen_reg + POSITION_WIDTH'(1));

    sse_matcher #(
        .NEEDLE_MAX     (NEEDLE_MAX),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_matcher (
        .cfg       (cfg),
        .window    (window_shift),
        .seen_now  (seen_now),
        .hit       (hit),
        .match_pos (match_pos)
    );

    // A result is due at the first match, or at the last byte without one;
    // after a match the remaining bytes of the haystack produce nothing.
    assign emit = !match_done_reg && (hit || s1_last_reg);

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_byte_next    = s1_byte_reg;
        s1_last_next    = s1_last_reg;
        window_next     = window_reg;
        bytes_seen_next = bytes_seen_reg;
        match_done_next = match_done_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_pos_next    = out_pos_reg;

        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
            if (!match_done_reg)
            begin
                window_next     = window_shift;
                bytes_seen_next = seen_now;
                match_done_next = hit;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_found_next = hit;
                out_pos_next   = hit ? match_pos : '0;
            end
            // The end of a haystack restarts the search for the next one.
            if (s1_last_reg)
            begin
                window_next     = '0;
                bytes_seen_next = '0;
                match_done_next = 1'b0;
            end
        end

        if (in_fire)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = in_ch.hay_byte;
            s1_last_next  = in_ch.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            window_reg     <= '0;
            bytes_seen_reg <= '0;
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            window_reg     <= window_next;
            bytes_seen_reg <= bytes_seen_next;
            match_done_reg <= match_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg   <= s1_byte_next;
        s1_last_reg   <= s1_last_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.found          = out_found_reg;
    assign out_ch.match_position = out_pos_reg;

`ifndef SYNTH
    // A "not found" result always reports position zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_pos_reg == '0)
        else $error("not-found result carries a nonzero position");

    // The end of a haystack leaves the search state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> bytes_seen_reg == '0 && !match_done_reg)
        else $error("search state not restarted after last byte");

    // A word waiting for a full result register is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg)
        else $error("stalled input word lost");
`endif

endmodule

@@ tb/substring_search_checker.sv @@
// Watches the substring search channels, predicts every result word and compares it.
`timescale 1ns / 1ps

module substring_search_checker
    import sse_pkg::*;
#(
    parameter int NEEDLE_MAX     = 16,
    parameter int POSITION_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    sse_in_if                          in_ch,
    sse_out_if                         out_ch,
    output int                         pending,
    output int                         fail_count
);

    typedef struct packed {
        logic                       found;
        logic [MATCH_POS_WIDTH-1:0] position;
    } search_result_t;

    logic [63:0]               needle_lo;
    logic [63:0]               needle_hi;
    logic [LENGTH_WIDTH-1:0]   needle_len;
    logic                      fold_on;
    logic [7:0]                window [NEEDLE_MAX];
    logic [POSITION_WIDTH-1:0] seen_count;
    logic                      matched;
    search_result_t            results_due [$];
    int                        mismatches;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (fold_on && (c >= 8'h41) && (c <= 8'h5A))
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] needle_at(input int k);
        if (k < 8)
        begin
            return needle_lo[k*8 +: 8];
        end
        return needle_hi[(k-8)*8 +: 8];
    endfunction

    function automatic void restart_search();
        int i;
        for (i = 0; i < NEEDLE_MAX; i++)
        begin
            window[i] = 8'h00;
        end
        seen_count = '0;
        matched    = 1'b0;
    endfunction

    // Advances the search by one haystack byte and queues the result it causes, if any.
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int                        i;
        int                        len;
        logic [POSITION_WIDTH-1:0] seen_now;
        logic [POSITION_WIDTH-1:0] start;
        logic                      hit;
        search_result_t            r;
        if (!matched)
        begin
            len = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
            for (i = NEEDLE_MAX - 1; i > 0; i--)
            begin
                window[i] = window[i-1];
            end
            window[0] = b;
            seen_now  = (&seen_count) ? seen_count : seen_count + 1'b1;
            start     = '0;
            if (len == 0)
            begin
                hit = 1'b1;
            end
            else if (seen_now < len)
            begin
                hit = 1'b0;
            end
            else
            begin
                hit = 1'b1;
                for (i = 0; i < len; i++)
                begin
                    if (lower_ascii(window[len-1-i]) != lower_ascii(needle_at(i)))
                    begin
                        hit = 1'b0;
                    end
                end
                start = seen_now - POSITION_WIDTH'(len);
            end
            seen_count = seen_now;
            if (hit)
            begin
                r.found    = 1'b1;
                r.position = MATCH_POS_WIDTH'(start);
                results_due.push_back(r);
                matched = 1'b1;
            end
            else if (last)
            begin
                r.found    = 1'b0;
                r.position = '0;
                results_due.push_back(r);
            end
        end
        if (last)
        begin
            restart_search();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        search_result_t due;
        if (!rst_n)
        begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = '0;
            fold_on    = 1'b0;
            restart_search();
            results_due.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result word with nothing pending: found=%0b match_position=%0d",
                           out_ch.found, out_ch.match_position);
                    mismatches++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (out_ch.found !== due.found)
                    begin
                        $error("found: expected %0b, actual %0b", due.found, out_ch.found);
                        mismatches++;
                    end
                    if (out_ch.match_position !== due.position)
                    begin
                        $error("match_position: expected %0d, actual %0d",
                               due.position, out_ch.match_position);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_NEEDLE_LOW:    needle_lo  = cfg_data;
                    CFG_NEEDLE_HIGH:   needle_hi  = cfg_data;
                    CFG_NEEDLE_LENGTH: needle_len = cfg_data[LENGTH_WIDTH-1:0];
                    CFG_FOLD_CASE:     fold_on    = cfg_data[0];
                    default:           ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                scan_byte(in_ch.hay_byte, in_ch.last_byte);
            end
            pending    <= results_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ tb/substring_search_engine_unit_tb.sv @@
// Stimulus and verdict for the substring search engine, with the checker beside the block.
`timescale 1ns / 1ps

module substring_search_engine_unit_tb;
    import sse_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RANDOM_WORDS = 1250;
    localparam int HOLD_CYCLES  = 300;
    // An accepted word passes the input register before reaching the result
    // register; the settle wait also covers any word that yields no result.
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 2000000;

    // Byte pool used for needles and haystacks: a few letters in both cases
    // plus the characters just outside the A-Z range, so that matches are
    // frequent and the case-fold boundaries are exercised.
    localparam logic [7:0] LETTERS [8] = '{"a", "b", "A", "B", "z", "Z", "@", "["};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    sse_in_if  in_ch ();
    sse_out_if out_ch ();

    int pending;
    int fail_count;

    // Pacing knobs, changed per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The stimulus flips hold_toggle to ask the receiver for one long hold-off.
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    // Configuration currently loaded, kept so that needles can be planted.
    logic [NEEDLE_BYTES-1:0][7:0] cur_needle;
    logic [LENGTH_WIDTH-1:0]      cur_len;
    logic                         cur_fold;

    int total_words = 0;

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    substring_search_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    substring_search_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Result side. Normally ready is drawn at random each cycle from the
    // current stall percentage. When the stimulus flips hold_toggle, ready is
    // held low through a long hold-off counted down from HOLD_CYCLES, so that
    // both internal stages fill and the block has to drop ready on its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen    <= hold_toggle;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one word and returns at the edge where it is accepted. Idle
    // cycles are inserted in front of the word at the sender's idle rate.
    // Valid stays high after acceptance so that back-to-back words never
    // lower and raise it within one time step.
    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.hay_byte  <= b;
        in_ch.last_byte <= fin;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        total_words++;
    endtask

    // Stops offering words and waits until every predicted result has been
    // taken, then lets the pipeline settle so that the block is idle.
    task automatic stop_and_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges; the write enable is
    // lowered only once, after the last of them.
    task automatic load_search(input logic [NEEDLE_BYTES-1:0][7:0] nd,
                               input logic [LENGTH_WIDTH-1:0] len, input logic fold);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NEEDLE_LOW;
        cfg_data  <= nd[7:0];
        @(posedge clk);
        cfg_index <= CFG_NEEDLE_HIGH;
        cfg_data  <= nd[15:8];
        @(posedge clk);
        cfg_index <= CFG_NEEDLE_LENGTH;
        cfg_data  <= CFG_DATA_WIDTH'(len);
        @(posedge clk);
        cfg_index <= CFG_FOLD_CASE;
        cfg_data  <= CFG_DATA_WIDTH'(fold);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_needle = nd;
        cur_len    = len;
        cur_fold   = fold;
    endtask

    function automatic logic [NEEDLE_BYTES-1:0][7:0] needle_of(input string s);
        logic [NEEDLE_BYTES-1:0][7:0] r;
        int                           i;
        r = '0;
        for (i = 0; i < s.len() && i < NEEDLE_BYTES; i++)
        begin
            r[i] = s[i];
        end
        return r;
    endfunction

    task automatic send_text(input string s, input logic close);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_word(s[i], close && (i == s.len() - 1));
        end
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 75)
        begin
            return LETTERS[$urandom_range(7)];
        end
        return 8'($urandom_range(255));
    endfunction

    // Draws a new configuration. Short needles dominate so that matches are
    // common; full-width needles and lengths past the needle storage show up
    // now and then.
    task automatic random_config();
        logic [NEEDLE_BYTES-1:0][7:0] nd;
        int                           roll;
        int                           len;
        int                           i;
        for (i = 0; i < NEEDLE_BYTES; i++)
        begin
            nd[i] = pick_byte();
        end
        roll = $urandom_range(99);
        if (roll < 8)
        begin
            len = 0;
        end
        else if (roll < 80)
        begin
            len = $urandom_range(1, 6);
        end
        else if (roll < 94)
        begin
            len = $urandom_range(7, 16);
        end
        else
        begin
            len = $urandom_range(17, 31);
        end
        load_search(nd, LENGTH_WIDTH'(len), 1'($urandom_range(1)));
    endtask

    // Builds one haystack from the byte pool, often with the needle planted
    // at a random offset (letters flipped in case when folding is on), and
    // sends it. Now and then the haystack is cut in two and the registers are
    // rewritten between the halves, while the block is idle mid-haystack.
    task automatic random_haystack();
        logic [7:0] hay [$];
        logic [7:0] c;
        int         hay_len;
        int         eff;
        int         plant_at;
        int         split;
        int         i;
        eff     = (cur_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(cur_len);
        hay_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
        for (i = 0; i < hay_len; i++)
        begin
            hay.push_back(pick_byte());
        end
        if (eff > 0 && $urandom_range(99) < 60)
        begin
            plant_at = $urandom_range(0, hay_len - 1);
            for (i = 0; i < eff; i++)
            begin
                c = cur_needle[i];
                if (cur_fold && $urandom_range(1) &&
                    ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
                begin
                    c = c ^ 8'h20;
                end
                if (plant_at + i < hay.size())
                begin
                    hay[plant_at + i] = c;
                end
                else
                begin
                    hay.push_back(c);
                end
            end
        end
        split = 0;
        if (hay.size() > 1 && $urandom_range(9) == 0)
        begin
            split = $urandom_range(1, hay.size() - 1);
        end
        for (i = 0; i < hay.size(); i++)
        begin
            if (split != 0 && i == split)
            begin
                stop_and_drain();
                random_config();
            end
            send_word(hay[i], i == hay.size() - 1);
        end
    endtask

    initial
    begin : stimulus
        logic [NEEDLE_BYTES-1:0][7:0] edge_needle;
        int                           i;
        int                           phase;
        int                           base;
        in_ch.valid     <= 1'b0;
        in_ch.hay_byte  <= 8'h00;
        in_ch.last_byte <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_NEEDLE_LOW;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        cur_needle = '0;
        cur_len    = '0;
        cur_fold   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side.
        // Registers are clear after reset, so the needle is empty: the first
        // byte matches at position 0 and the second byte yields nothing.
        send_text("qz", 1'b1);
        stop_and_drain();
        load_search(needle_of("abc"), 5'd3, 1'b0);
        // Match in the middle; the bytes after it produce no word.
        send_text("xabcq", 1'b1);
        // Haystack shorter than the needle ends without a match.
        send_text("ab", 1'b1);
        // The match completes on the final byte of the haystack.
        send_text("zabc", 1'b1);
        stop_and_drain();
        load_search(needle_of("hello"), 5'd5, 1'b1);
        // Case-insensitive match against mixed case.
        send_text("xHeLLo", 1'b1);
        stop_and_drain();
        // The characters just outside A-Z must not be folded onto backquote and brace.
        load_search(needle_of("@["), 5'd2, 1'b1);
        send_text("`{", 1'b1);
        stop_and_drain();
        // Full-length needle of all-ones and all-zeros bytes.
        for (i = 0; i < NEEDLE_BYTES; i++)
        begin
            edge_needle[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
        end
        load_search(edge_needle, 5'd16, 1'b0);
        for (i = 0; i < NEEDLE_BYTES; i++)
        begin
            send_word(edge_needle[i], i == NEEDLE_BYTES - 1);
        end
        stop_and_drain();
        // Registers rewritten mid-haystack: the bytes already in the window
        // are compared against the new needle.
        load_search(needle_of("ab"), 5'd2, 1'b0);
        send_text("xa", 1'b0);
        stop_and_drain();
        load_search(needle_of("ac"), 5'd2, 1'b0);
        send_text("c", 1'b1);

        // Random part in four pacing phases.
        base = total_words;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            if (phase == 0)
            begin
                // Back-pressure burst: with an empty needle and every word
                // marked last, each word yields a result, so a long receiver
                // hold-off fills the block and stalls its input.
                stop_and_drain();
                load_search(needle_of(""), 5'd0, 1'b0);
                hold_toggle <= ~hold_toggle;
                repeat (24) send_word(8'($urandom_range(255)), 1'b1);
            end
            while (total_words - base < RANDOM_WORDS * (phase + 1) / 4)
            begin
                if ($urandom_range(2) == 0)
                begin
                    stop_and_drain();
                    random_config();
                end
                random_haystack();
            end
        end

        stop_and_drain();
        if (fail_count == 0 && pending == 0)
        begin
            $display("substring_search_engine_unit_tb: done, clean");
        end
        else
        begin
            $display("substring_search_engine_unit_tb: done, errors");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a result that never arrives ends here.
    initial
    begin
        #(TIMEOUT_NS);
        $display("substring_search_engine_unit_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sse_pkg.sv
sv/sse_if.sv
sv/sse_cfg_regs.sv
sv/sse_matcher.sv
sv/substring_search_engine_unit.sv
tb/substring_search_checker.sv
tb/substring_search_engine_unit_tb.sv
